>>> sv/nss_pkg.sv
`default_nettype none
package nss_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int MAX_DIMS    = 8;
  localparam int COORD_BITS  = 16;

  localparam int SIDX_W = $clog2(MAX_SAMPLES);
  localparam int DIDX_W = $clog2(MAX_DIMS);
  localparam int ADDR_W = SIDX_W + DIDX_W;
  localparam int STORE_DEPTH = MAX_SAMPLES * MAX_DIMS;

  localparam int DIMS_W     = 4;
  localparam int SAMP_W     = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Control that travels alongside one coordinate through the datapath.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              tail;
    logic [SIDX_W-1:0] idx;
  } nss_ctl_t;

endpackage
`default_nettype wire

>>> sv/nss_ram.sv
`default_nettype none
module nss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/nss_mac.sv
`default_nettype none
module nss_mac (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire nss_pkg::nss_ctl_t                     ctl_in,
  input  wire logic [nss_pkg::COORD_BITS-1:0]        a,
  input  wire logic [nss_pkg::COORD_BITS-1:0]        b,
  output nss_pkg::nss_ctl_t                          dist_ctl,
  output logic      [nss_pkg::DIST_W-1:0]            dist_sum
);

  localparam logic [nss_pkg::COORD_BITS-1:0] SIGN_BIT =
    {1'b1, {(nss_pkg::COORD_BITS-1){1'b0}}};

  logic [nss_pkg::COORD_BITS-1:0] a_b, b_b, mag_next, mag;
  logic [nss_pkg::SQ_W-1:0]       sq;
  logic [nss_pkg::DIST_W-1:0]     acc_next;
  nss_pkg::nss_ctl_t              ctl1, ctl2, ctl_out;

  // Flipping the sign bit gives offset binary, which orders like the signed value.
  always_comb begin
    a_b = a ^ SIGN_BIT;
    b_b = b ^ SIGN_BIT;
    mag_next = (a_b > b_b) ? (a_b - b_b) : (b_b - a_b);
    acc_next = ctl2.first ? nss_pkg::DIST_W'(sq) : dist_sum + nss_pkg::DIST_W'(sq);
    ctl_out = ctl2;
    ctl_out.valid = ctl2.valid && ctl2.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1     <= '0;
      ctl2     <= '0;
      dist_ctl <= '0;
    end else begin
      ctl1     <= ctl_in;
      ctl2     <= ctl1;
      dist_ctl <= ctl_out;
    end
    mag <= mag_next;
    sq  <= mag * mag;
    if (ctl2.valid) begin
      dist_sum <= acc_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/nss_seq.sv
`default_nettype none
module nss_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [nss_pkg::DIMS_W-1:0]    dims_in_use,
  input  wire logic [nss_pkg::SAMP_W-1:0]    samples_in_use,
  input  wire nss_pkg::nss_ctl_t             dist_ctl,
  input  wire logic [nss_pkg::DIST_W-1:0]    dist_sum,
  output logic                               busy,
  output nss_pkg::nss_ctl_t                  issue,
  output logic      [nss_pkg::SIDX_W-1:0]    s_cnt,
  output logic      [nss_pkg::DIDX_W-1:0]    d_cnt,
  output logic                               done,
  output logic      [nss_pkg::SIDX_W-1:0]    result
);

  typedef enum logic [1:0] {IDLE, ISSUE, DRAIN} state_t;

  state_t                       state;
  logic [nss_pkg::DIMS_W-1:0]   nd;
  logic [nss_pkg::SAMP_W-1:0]   ns;
  logic [nss_pkg::DIDX_W-1:0]   nd_m1;
  logic [nss_pkg::SIDX_W-1:0]   ns_m1;
  logic                         empty_scan;
  logic                         d_last, s_last, better;
  logic [nss_pkg::DIST_W-1:0]   best_dist;
  logic [nss_pkg::SIDX_W-1:0]   best_idx, win_idx;

  always_comb begin
    nd = (dims_in_use > nss_pkg::DIMS_W'(nss_pkg::MAX_DIMS)) ?
         nss_pkg::DIMS_W'(nss_pkg::MAX_DIMS) : dims_in_use;
    ns = (samples_in_use > nss_pkg::SAMP_W'(nss_pkg::MAX_SAMPLES)) ?
         nss_pkg::SAMP_W'(nss_pkg::MAX_SAMPLES) : samples_in_use;
    nd_m1 = nss_pkg::DIDX_W'(nd - 1'b1);
    ns_m1 = nss_pkg::SIDX_W'(ns - 1'b1);
    empty_scan = (dims_in_use == '0) || (samples_in_use == '0);
    d_last = (d_cnt == nd_m1);
    s_last = (s_cnt == ns_m1);
    busy = (state != IDLE);
    issue.valid = (state == ISSUE);
    issue.first = (d_cnt == '0);
    issue.last  = d_last;
    issue.tail  = s_last;
    issue.idx   = s_cnt;
    // Strict compare keeps the lowest index on a tie.
    better  = dist_sum < best_dist;
    win_idx = better ? dist_ctl.idx : best_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      done      <= 1'b0;
      s_cnt     <= '0;
      d_cnt     <= '0;
      best_dist <= '1;
      best_idx  <= '0;
    end else begin
      done <= ((state == IDLE) && go && empty_scan) ||
              ((state == DRAIN) && dist_ctl.valid && dist_ctl.tail);
      if (dist_ctl.valid && better) begin
        best_dist <= dist_sum;
        best_idx  <= dist_ctl.idx;
      end
      unique case (state)
        IDLE: begin
          if (go) begin
            s_cnt     <= '0;
            d_cnt     <= '0;
            best_dist <= '1;
            best_idx  <= '0;
            if (empty_scan) begin
              result <= '0;
            end else begin
              state <= ISSUE;
            end
          end
        end
        ISSUE: begin
          if (d_last) begin
            d_cnt <= '0;
            s_cnt <= s_cnt + 1'b1;
            if (s_last) begin
              state <= DRAIN;
            end
          end else begin
            d_cnt <= d_cnt + 1'b1;
          end
        end
        DRAIN: begin
          if (dist_ctl.valid && dist_ctl.tail) begin
            result <= win_idx;
            state  <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/nearest_sample_search_unit.sv
`default_nettype none
// Channel  | Signals                                              | Handshake
// ---------+------------------------------------------------------+-------------------------
// item in  | op sample_index coord_index coord_value last_coord   | start high, busy low
// result   | nearest_index                                        | done high for one cycle
// config   | cfg_index cfg_data                                   | cfg_we high
//
// Load items and query items without last_coord never raise busy.
// A query item with last_coord starts a scan (with zero dims or samples it gives result
// zero without a scan): one shared subtract-square-accumulate unit handles one coordinate
// per cycle, fed by the sample memory's single read port. busy drops as the result shows.
// Reset clears control and query point, sets dims 1, samples 64; sample memory is kept.
// The receiver cannot stall: nearest_index is valid only in the cycle done is high.
module nearest_sample_search_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 op,
  input  wire logic [nss_pkg::SIDX_W-1:0]           sample_index,
  input  wire logic [nss_pkg::DIDX_W-1:0]           coord_index,
  input  wire logic signed [nss_pkg::COORD_BITS-1:0] coord_value,
  input  wire logic                                 last_coord,
  output logic                                      done,
  output logic      [nss_pkg::SIDX_W-1:0]           nearest_index,
  input  wire logic                                 cfg_we,
  input  wire logic [nss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [nss_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [nss_pkg::DIMS_W-1:0]     dims_in_use;
  logic [nss_pkg::SAMP_W-1:0]     samples_in_use;
  logic [nss_pkg::COORD_BITS-1:0] query_point [nss_pkg::MAX_DIMS];
  logic [nss_pkg::COORD_BITS-1:0] q_val, s_val;
  logic                           accept, load_we, go;
  nss_pkg::nss_ctl_t              issue, issue_d, dist_ctl;
  logic [nss_pkg::SIDX_W-1:0]     s_cnt;
  logic [nss_pkg::DIDX_W-1:0]     d_cnt;
  logic [nss_pkg::DIST_W-1:0]     dist_sum;

  assign accept  = start && !busy;
  assign load_we = accept && (op == nss_pkg::OP_LOAD);
  assign go      = accept && (op == nss_pkg::OP_QUERY) && last_coord;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use    <= nss_pkg::DIMS_W'(1);
      samples_in_use <= nss_pkg::SAMP_W'(nss_pkg::MAX_SAMPLES);
      for (int i = 0; i < nss_pkg::MAX_DIMS; i++) begin
        query_point[i] <= '0;
      end
      issue_d <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          nss_pkg::CFG_DIMS:    dims_in_use    <= nss_pkg::DIMS_W'(cfg_data);
          nss_pkg::CFG_SAMPLES: samples_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (accept && (op == nss_pkg::OP_QUERY)) begin
        query_point[coord_index] <= coord_value;
      end
      issue_d <= issue;
    end
    // Query coordinate lines up with the memory's registered read data.
    q_val <= query_point[d_cnt];
  end

  nss_ram #(
    .WIDTH (nss_pkg::COORD_BITS),
    .DEPTH (nss_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr ({sample_index, coord_index}),
    .wdata (coord_value),
    .raddr ({s_cnt, d_cnt}),
    .rdata (s_val)
  );

  nss_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .dims_in_use    (dims_in_use),
    .samples_in_use (samples_in_use),
    .dist_ctl       (dist_ctl),
    .dist_sum       (dist_sum),
    .busy           (busy),
    .issue          (issue),
    .s_cnt          (s_cnt),
    .d_cnt          (d_cnt),
    .done           (done),
    .result         (nearest_index)
  );

  nss_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (issue_d),
    .a        (q_val),
    .b        (s_val),
    .dist_ctl (dist_ctl),
    .dist_sum (dist_sum)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while the scan is still running");

  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op && last_coord) |=> (busy || done))
    else $error("search item neither started a scan nor gave a result");

  a_end_has_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("scan ended without a result");

endmodule
`default_nettype wire

>>> tb/nearest_sample_search_unit_test.sv
`timescale 1ns / 1ps

import nss_pkg::*;

class nearest_scoreboard;
  logic [COORD_BITS-1:0] sample_mem [MAX_SAMPLES][MAX_DIMS];
  logic [COORD_BITS-1:0] query_pt [MAX_DIMS];
  logic [DIMS_W-1:0]     dims_reg;
  logic [SAMP_W-1:0]     samples_reg;
  logic [SIDX_W-1:0]     expected_nearest [$];
  int                    mismatches;

  function new();
    dims_reg    = DIMS_W'(1);
    samples_reg = SAMP_W'(64);
    mismatches  = 0;
    foreach (query_pt[d]) query_pt[d] = '0;
    foreach (sample_mem[s, d]) sample_mem[s][d] = '0;
  endfunction

  function int pending();
    return expected_nearest.size();
  endfunction

  function int dims_eff();
    return (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
  endfunction

  function int samples_eff();
    return (samples_reg > MAX_SAMPLES) ? MAX_SAMPLES : int'(samples_reg);
  endfunction

  function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_DIMS) dims_reg = data[DIMS_W-1:0];
    else if (idx == CFG_SAMPLES) samples_reg = data[SAMP_W-1:0];
  endfunction

  // Flipping the sign bit gives an offset-binary value whose unsigned order
  // matches the signed order, so the difference magnitude is exact.
  function logic [SIDX_W-1:0] nearest_sample();
    logic [63:0]       best_dist, dist_sum, qa, sa, diff;
    logic [SIDX_W-1:0] best_idx;
    int                nd, ns;
    nd = dims_eff();
    ns = samples_eff();
    best_dist = '1;
    best_idx  = '0;
    for (int s = 0; s < ns; s++) begin
      dist_sum = '0;
      for (int d = 0; d < nd; d++) begin
        qa = 64'({~query_pt[d][COORD_BITS-1], query_pt[d][COORD_BITS-2:0]});
        sa = 64'({~sample_mem[s][d][COORD_BITS-1], sample_mem[s][d][COORD_BITS-2:0]});
        diff = (qa > sa) ? qa - sa : sa - qa;
        dist_sum = dist_sum + diff * diff;
      end
      if (dist_sum < best_dist) begin
        best_dist = dist_sum;
        best_idx  = SIDX_W'(s);
      end
    end
    return best_idx;
  endfunction

  function void note_item(logic o, logic [SIDX_W-1:0] si, logic [DIDX_W-1:0] ci,
                          logic [COORD_BITS-1:0] v, logic l);
    if (o == OP_LOAD) begin
      sample_mem[si][ci] = v;
    end else begin
      query_pt[ci] = v;
      if (l) expected_nearest.push_back(nearest_sample());
    end
  endfunction

  function void check_result(logic [SIDX_W-1:0] got);
    logic [SIDX_W-1:0] want;
    if (expected_nearest.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: nearest_index %0d reported with no query pending", got);
    end else begin
      want = expected_nearest.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: nearest_index expected %0d got %0d", want, got);
      end
    end
  endfunction
endclass

module nearest_sample_search_unit_test;

  localparam int RANDOM_ITEMS = 630;
  localparam int PHASE_ITEMS  = 90;
  localparam int MAX_GAP      = 12;
  localparam int MAX_SCAN     = MAX_SAMPLES * MAX_DIMS + 8;
  localparam int SETTLE       = 8;
  localparam int ITEM_BUDGET  = STORE_DEPTH + 60 + RANDOM_ITEMS + 2 * PHASE_ITEMS;
  localparam int CYCLE_LIMIT  = 4 * ITEM_BUDGET * (MAX_SCAN + MAX_GAP + 4);

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         op;
  logic [SIDX_W-1:0]            sample_index;
  logic [DIDX_W-1:0]            coord_index;
  logic signed [COORD_BITS-1:0] coord_value;
  logic                         last_coord;
  logic                         done;
  logic [SIDX_W-1:0]            nearest_index;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  nearest_scoreboard sb = new();
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;

  nearest_sample_search_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .sample_index(sample_index), .coord_index(coord_index),
    .coord_value(coord_value), .last_coord(last_coord), .done(done),
    .nearest_index(nearest_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.note_config(cfg_index, cfg_data);
      if (start && !busy) sb.note_item(op, sample_index, coord_index, coord_value, last_coord);
      if (done) sb.check_result(nearest_index);
    end
  end

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(COORD_BITS-1){1'b1}}};
      1: return {1'b1, {(COORD_BITS-1){1'b0}}};
      2, 3, 4: return COORD_BITS'($urandom_range(0, 511) - 256);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(logic o, logic [SIDX_W-1:0] si, logic [DIDX_W-1:0] ci,
                           logic [COORD_BITS-1:0] v, logic l);
    start        <= 1'b1;
    op           <= o;
    sample_index <= si;
    coord_index  <= ci;
    coord_value  <= v;
    last_coord   <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Items go out in bursts; a gap before a burst is skipped now and then.
  task automatic paced_send(logic o, logic [SIDX_W-1:0] si, logic [DIDX_W-1:0] ci,
                            logic [COORD_BITS-1:0] v, logic l);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, MAX_GAP));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_item(o, si, ci, v, l);
  endtask

  // The extra edge first lets the monitor see the last accepted item.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] dims_data,
                            logic [CFG_DATA_W-1:0] samples_data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIMS;
    cfg_data  <= dims_data;
    @(posedge clk);
    cfg_index <= CFG_SAMPLES;
    cfg_data  <= samples_data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_config();
    logic [CFG_DATA_W-1:0] dd, sd;
    case ($urandom_range(0, 7))
      0: dd = '0;
      1: dd = CFG_DATA_W'($urandom_range(9, 127));
      default: dd = CFG_DATA_W'($urandom_range(1, MAX_DIMS));
    endcase
    case ($urandom_range(0, 9))
      0: sd = '0;
      1, 2: sd = CFG_DATA_W'($urandom_range(MAX_SAMPLES, 127));
      3: sd = 1;
      default: sd = CFG_DATA_W'($urandom_range(2, 20));
    endcase
    set_config(dd, sd);
  endtask

  // Mostly complete query points ending in last_coord, mixed with loads,
  // duplicated samples for ties, and stray items.
  task automatic run_phase(int n_items);
    int                    target, act, nd, ns, base, dst, mode;
    logic [COORD_BITS-1:0] v;
    target = items_sent + n_items;
    while (items_sent < target) begin
      nd  = sb.dims_eff();
      ns  = sb.samples_eff();
      act = $urandom_range(0, 99);
      if (act < 55) begin
        base = $urandom_range(0, (ns > 0) ? ns - 1 : 0);
        mode = $urandom_range(0, 9);
        if (nd == 0) begin
          paced_send(OP_QUERY, SIDX_W'($urandom), DIDX_W'($urandom), rand_coord(), 1'b1);
        end else begin
          for (int d = 0; d < nd; d++) begin
            if (mode < 4)
              v = COORD_BITS'(sb.sample_mem[base][d] +
                              COORD_BITS'($urandom_range(0, 6)) - 3);
            else if (mode < 6)
              v = sb.sample_mem[base][d];
            else
              v = rand_coord();
            paced_send(OP_QUERY, SIDX_W'($urandom), DIDX_W'(d), v, d == nd - 1);
          end
        end
      end else if (act < 80) begin
        base = (ns > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, ns - 1)
                                                      : $urandom_range(0, MAX_SAMPLES - 1);
        paced_send(OP_LOAD, SIDX_W'(base), DIDX_W'($urandom), rand_coord(),
                   1'($urandom_range(0, 1)));
      end else if (act < 86) begin
        base = $urandom_range(0, MAX_SAMPLES - 1);
        dst  = $urandom_range(0, (ns > 1) ? ns - 1 : 0);
        for (int d = 0; d < MAX_DIMS; d++)
          paced_send(OP_LOAD, SIDX_W'(dst), DIDX_W'(d), sb.sample_mem[base][d], 1'b0);
      end else begin
        paced_send(1'($urandom_range(0, 1)), SIDX_W'($urandom), DIDX_W'($urandom),
                   rand_coord(), $urandom_range(0, 4) == 0);
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    op           <= OP_LOAD;
    sample_index <= '0;
    coord_index  <= '0;
    coord_value  <= '0;
    last_coord   <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_DIMS;
    cfg_data     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every sample entry is written before any scan can read it.
    for (int s = 0; s < MAX_SAMPLES; s++)
      for (int d = 0; d < MAX_DIMS; d++)
        paced_send(OP_LOAD, SIDX_W'(s), DIDX_W'(d), rand_coord(), 1'($urandom_range(0, 1)));

    // Largest positive and negative coordinates, then an exact tie.
    set_config(1, 2);
    send_item(OP_LOAD, 0, 0, 16'h7FFF, 1'b0);
    send_item(OP_LOAD, 1, 0, 16'h8000, 1'b0);
    send_item(OP_QUERY, 0, 0, 16'h7FFF, 1'b1);
    send_item(OP_QUERY, 63, 0, 16'h8000, 1'b1);
    send_item(OP_LOAD, 1, 0, 16'h7FFF, 1'b1);
    send_item(OP_QUERY, 0, 0, 16'h7FFF, 1'b1);
    send_item(OP_QUERY, 0, 0, 16'h0000, 1'b1);

    // With no dimensions or no samples the answer is sample zero.
    set_config(0, 2);
    send_item(OP_QUERY, 0, 5, 16'h1234, 1'b1);
    set_config(8, 0);
    send_item(OP_QUERY, 0, 7, 16'hFFFF, 1'b1);

    // Oversized register values are clamped to the table size.
    set_config(7'h7F, 7'h7F);
    for (int d = 0; d < MAX_DIMS; d++)
      send_item(OP_QUERY, SIDX_W'(d), DIDX_W'(d), (d % 2) ? 16'h8000 : 16'h7FFF,
                d == MAX_DIMS - 1);
    send_item(OP_QUERY, 0, 3, 16'h0000, 1'b1);
    set_config(MAX_DIMS, MAX_SAMPLES);
    send_item(OP_QUERY, 0, 0, 16'h0100, 1'b1);
    set_config(MAX_DIMS, 1);
    send_item(OP_QUERY, 0, 1, 16'hFF00, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick_config();
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (MAX_SCAN + 16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
sv/nss_pkg.sv
sv/nss_ram.sv
sv/nss_mac.sv
sv/nss_seq.sv
sv/nearest_sample_search_unit.sv
tb/nearest_sample_search_unit_test.sv
